// ===== rtl/ibs_pkg.sv =====
// ----------------------------------------------------------------------------
// ibs_pkg: shared types and constants for iterative box smoothing
// Grid geometry, field widths, command codes and sequencer status.
// ----------------------------------------------------------------------------
`default_nettype none
package ibs_pkg;
  localparam int MaxRows  = 128;
  localparam int MaxCols  = 128;
  localparam int RowW     = $clog2(MaxRows);
  localparam int ColW     = $clog2(MaxCols);
  localparam int AddrW    = RowW + ColW;
  localparam int Cells    = MaxRows * MaxCols;
  localparam int DimW     = 8;
  localparam int PassW    = 16;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRead = 1'b1;

  localparam logic [1:0] RegRows   = 2'd0;
  localparam logic [1:0] RegCols   = 2'd1;
  localparam logic [1:0] RegThresh = 2'd2;
  localparam logic [1:0] RegPasses = 2'd3;

  typedef struct packed {
    logic [RowW-1:0] last_row;
    logic [ColW-1:0] last_col;
    logic [7:0]      thresh;
    logic [PassW-1:0] limit;
  } geom_t;

  typedef struct packed {
    logic            busy;
    logic [PassW-1:0] passes;
    logic            limit_hit;
  } eng_stat_t;

  // Clamp a size register to 1..Max, returned minus one.
  function automatic logic [RowW-1:0] last_row_of(input logic [DimW-1:0] v);
    logic [DimW:0] t;
    t = (v == '0) ? 9'd1 : {1'b0, v};
    if (t > (DimW+1)'(MaxRows)) t = (DimW+1)'(MaxRows);
    last_row_of = RowW'(t - 9'd1);
  endfunction

  function automatic logic [ColW-1:0] last_col_of(input logic [DimW-1:0] v);
    logic [DimW:0] t;
    t = (v == '0) ? 9'd1 : {1'b0, v};
    if (t > (DimW+1)'(MaxCols)) t = (DimW+1)'(MaxCols);
    last_col_of = ColW'(t - 9'd1);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/ibs_if.sv =====
// ----------------------------------------------------------------------------
// ibs stream interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface ibs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] pixel;
  modport source (output valid, cmd, pixel, input ready);
  modport sink   (input valid, cmd, pixel, output ready);
endinterface

interface ibs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  smoothed;
  logic        last_cell;
  logic [15:0] pass_count;
  logic        limit_hit;
  modport source (output valid, smoothed, last_cell, pass_count, limit_hit, input ready);
  modport sink   (input valid, smoothed, last_cell, pass_count, limit_hit, output ready);
endinterface

interface ibs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/iterative_box_smoothing.sv =====
// ----------------------------------------------------------------------------
// iterative_box_smoothing: 3x3 box smoothing until convergence
// Loads a grid, smooths it in repeated passes, streams the result back.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  in_ch    in   cmd, pixel
//  out_ch   out  smoothed, last_cell, pass_count, limit_hit
//  cfg_ch   in   index (0 rows, 1 cols, 2 diff_threshold, 3 max_passes), data
//
// Each load writes one source cell; the last load starts the passes. Each
// pass smooths and then checks every cell, both bound by the single result
// memory port. A read goes through the memory read register, then the output
// register; in_ch is held off while a result waits or a pass runs. Reset is
// synchronous and clears all control state; grid memories are not cleared.
`default_nettype none
module iterative_box_smoothing (
  input wire logic clk,
  input wire logic rst,
  ibs_in_if.sink   in_ch,
  ibs_out_if.source out_ch,
  ibs_cfg_if.sink  cfg_ch
);
  logic [7:0]  rows, cols, thresh;
  logic [15:0] max_passes;
  ibs_pkg::geom_t geom;
  ibs_pkg::eng_stat_t stat;

  logic [ibs_pkg::RowW-1:0] ld_r, rd_r;
  logic [ibs_pkg::ColW-1:0] ld_c, rd_c;
  logic done, rd_pend, start;

  logic [ibs_pkg::AddrW-1:0] e_src_addr, e_res_addr, res_addr;
  logic [7:0] src_rdata, res_rdata, e_wdata;
  logic e_we;
  logic in_xfer, ld_xfer, rd_xfer, last_ld, rd_last;

  assign geom.last_row = ibs_pkg::last_row_of(rows);
  assign geom.last_col = ibs_pkg::last_col_of(cols);
  assign geom.thresh   = thresh;
  assign geom.limit    = (max_passes == '0) ? 16'd1 : max_passes;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !stat.busy && !start && !rd_pend && !out_ch.valid;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign ld_xfer = in_xfer && (in_ch.cmd == ibs_pkg::CmdLoad);
  assign rd_xfer = in_xfer && (in_ch.cmd == ibs_pkg::CmdRead) && done;
  assign last_ld = (ld_r == geom.last_row) && (ld_c == geom.last_col);
  assign rd_last = (rd_r == geom.last_row) && (rd_c == geom.last_col);
  assign res_addr = stat.busy ? e_res_addr : {rd_r, rd_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= 8'd8; cols <= 8'd8; thresh <= 8'd1; max_passes <= 16'd1000;
      ld_r <= '0; ld_c <= '0; rd_r <= '0; rd_c <= '0;
      done <= 1'b0; rd_pend <= 1'b0; start <= 1'b0; out_ch.valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          ibs_pkg::RegRows: begin
            rows <= cfg_ch.data[7:0];
            ld_r <= '0; ld_c <= '0; rd_r <= '0; rd_c <= '0; done <= 1'b0;
          end
          ibs_pkg::RegCols: begin
            cols <= cfg_ch.data[7:0];
            ld_r <= '0; ld_c <= '0; rd_r <= '0; rd_c <= '0; done <= 1'b0;
          end
          ibs_pkg::RegThresh: thresh <= cfg_ch.data[7:0];
          ibs_pkg::RegPasses: max_passes <= cfg_ch.data;
          default: ;
        endcase
      end
      if (ld_xfer) begin
        done <= 1'b0;
        if (last_ld) begin
          ld_r <= '0; ld_c <= '0; start <= 1'b1; rd_r <= '0; rd_c <= '0;
        end else if (ld_c == geom.last_col) begin
          ld_c <= '0; ld_r <= ld_r + 1'b1;
        end else ld_c <= ld_c + 1'b1;
      end
      if (start) done <= 1'b1;
      // result memory data arrives in the cycle after the read transfer
      rd_pend <= rd_xfer;
      if (rd_xfer) begin
        out_ch.last_cell <= rd_last;
        if (rd_last) begin
          rd_r <= '0; rd_c <= '0;
        end else if (rd_c == geom.last_col) begin
          rd_c <= '0; rd_r <= rd_r + 1'b1;
        end else rd_c <= rd_c + 1'b1;
      end
      if (rd_pend) begin
        out_ch.valid      <= 1'b1;
        out_ch.smoothed   <= res_rdata;
        out_ch.pass_count <= stat.passes;
        out_ch.limit_hit  <= stat.limit_hit;
      end else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  ibs_engine u_engine (
    .clk, .rst, .start, .geom, .stat,
    .src_addr(e_src_addr), .src_data(src_rdata),
    .res_addr(e_res_addr), .res_data(res_rdata),
    .res_we(e_we), .res_wdata(e_wdata)
  );

  ibs_grids u_grids (
    .clk,
    .src_we(ld_xfer), .src_waddr({ld_r, ld_c}), .src_wdata(in_ch.pixel),
    .src_raddr(e_src_addr), .src_rdata,
    .res_we(e_we), .res_addr, .res_wdata(e_wdata), .res_rdata
  );
endmodule
`default_nettype wire

// ===== rtl/ibs_engine.sv =====
// ----------------------------------------------------------------------------
// ibs_engine: smoothing sequencer
// Walks the grid cell by cell, reading neighbors from memory one at a time,
// summing them for smoothing and comparing them for convergence.
// ----------------------------------------------------------------------------
`default_nettype none
module ibs_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire ibs_pkg::geom_t             geom,
  output ibs_pkg::eng_stat_t              stat,
  // source grid read port
  output logic [ibs_pkg::AddrW-1:0]       src_addr,
  input  wire logic [7:0]                 src_data,
  // result grid access
  output logic [ibs_pkg::AddrW-1:0]       res_addr,
  input  wire logic [7:0]                 res_data,
  output logic                            res_we,
  output logic [7:0]                      res_wdata
);
  typedef enum logic [2:0] {S_IDLE, S_RD, S_DIV, S_WR, S_CK_RD, S_CK_CMP, S_END} state_t;

  state_t                  state;
  logic [ibs_pkg::RowW-1:0] r;
  logic [ibs_pkg::ColW-1:0] c;
  logic [3:0]              k;     // neighbor slot 0..8 (9 only drains), center is 4
  logic [3:0]              k_d;   // slot of the word now on the read bus
  logic                    rd_ok; // slot in the grid, data valid next cycle
  logic                    first;
  logic [11:0]             sum;
  logic [7:0]              center;
  logic [7:0]              best;
  logic                    any;
  logic [ibs_pkg::PassW-1:0] passes;
  logic                    lim;
  logic [11:0]             quot;

  logic [1:0]              kr, kc;
  logic signed [ibs_pkg::RowW+1:0] nr;
  logic signed [ibs_pkg::ColW+1:0] nc;
  logic                    in_grid;
  logic                    edge_r, edge_c;
  logic [7:0]              rd_data;
  logic [7:0]              diff;

  always_comb begin
    // split the slot into row and column offsets of the 3x3 window
    kr = (k >= 4'd6) ? 2'd2 : (k >= 4'd3) ? 2'd1 : 2'd0;
    kc = 2'(k - {1'b0, kr, 1'b0} - {2'b00, kr});
    nr = $signed({2'b00, r}) + $signed({{ibs_pkg::RowW{1'b0}}, kr})
       - (ibs_pkg::RowW+2)'(1);
    nc = $signed({2'b00, c}) + $signed({{ibs_pkg::ColW{1'b0}}, kc})
       - (ibs_pkg::ColW+2)'(1);
    in_grid = (nr >= 0) && (nc >= 0)
           && (nr <= $signed({2'b00, geom.last_row}))
           && (nc <= $signed({2'b00, geom.last_col}));
    src_addr = {nr[ibs_pkg::RowW-1:0], nc[ibs_pkg::ColW-1:0]};
    edge_r = (r == '0) || (r == geom.last_row);
    edge_c = (c == '0) || (c == geom.last_col);
    rd_data = first ? src_data : res_data;
    diff = (center > res_data) ? center - res_data : res_data - center;
    // constant-divisor quotients by reciprocal multiply with range <= 2295
    if (!edge_r && !edge_c) quot = 12'((24'(sum) * 24'd7282) >> 16);
    else if (edge_r && edge_c) quot = sum >> 2;
    else quot = 12'((24'(sum) * 24'd10923) >> 16);
    res_we    = (state == S_WR);
    res_wdata = quot[7:0];
    res_addr  = res_we ? {r, c} : src_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      passes <= '0;
      lim <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (start) begin
          state <= S_RD; r <= '0; c <= '0; k <= '0; sum <= '0;
          first <= 1'b1; passes <= '0; lim <= 1'b0; rd_ok <= 1'b0;
        end
        S_RD: begin
          // issue slot k, accumulate slot k-1; slot 9 is only a drain cycle
          if (rd_ok) sum <= sum + 12'(rd_data);
          rd_ok <= in_grid && (k != 4'd9);
          if (k == 4'd9) state <= S_DIV;
          else k <= k + 4'd1;
        end
        S_DIV: begin
          if (rd_ok) sum <= sum + 12'(rd_data);
          rd_ok <= 1'b0;
          state <= S_WR;
        end
        S_WR: begin
          k <= '0; sum <= '0;
          if (c == geom.last_col) begin
            c <= '0;
            if (r == geom.last_row) begin
              r <= '0; passes <= passes + 1'b1; first <= 1'b0;
              any <= 1'b0; best <= '0; k <= 4'd4; state <= S_CK_RD;
            end else begin
              r <= r + 1'b1; state <= S_RD;
            end
          end else begin
            c <= c + 1'b1; state <= S_RD;
          end
        end
        S_CK_RD: begin
          // slot 4 read first gives the center; then the other eight
          k_d <= k; rd_ok <= in_grid;
          if (k == 4'd4) k <= '0;
          else if (k == 4'd3) k <= 4'd5;
          else k <= k + 4'd1;
          state <= S_CK_CMP;
        end
        S_CK_CMP: begin
          if (k_d == 4'd4) center <= res_data;
          else if (rd_ok && res_data != 8'd0) begin
            any <= 1'b1;
            if (diff > best) best <= diff;
          end
          if (k_d == 4'd8) begin
            k <= 4'd4;
            if (c == geom.last_col) begin
              c <= '0;
              if (r == geom.last_row) state <= S_END;
              else begin r <= r + 1'b1; state <= S_CK_RD; end
            end else begin
              c <= c + 1'b1; state <= S_CK_RD;
            end
          end else state <= S_CK_RD;
        end
        S_END: begin
          r <= '0; c <= '0; k <= '0; sum <= '0; rd_ok <= 1'b0;
          if (!any || best <= geom.thresh) state <= S_IDLE;
          else if (passes >= geom.limit) begin lim <= 1'b1; state <= S_IDLE; end
          else state <= S_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy      = (state != S_IDLE);
  assign stat.passes    = passes;
  assign stat.limit_hit = lim;
endmodule
`default_nettype wire

// ===== rtl/ibs_grids.sv =====
// ----------------------------------------------------------------------------
// ibs_grids: source and result grid memories
// Source: one write and one registered read port; result: one shared port.
// ----------------------------------------------------------------------------
`default_nettype none
module ibs_grids (
  input  wire logic                     clk,
  input  wire logic                     src_we,
  input  wire logic [ibs_pkg::AddrW-1:0] src_waddr,
  input  wire logic [7:0]               src_wdata,
  input  wire logic [ibs_pkg::AddrW-1:0] src_raddr,
  output logic [7:0]                    src_rdata,
  input  wire logic                     res_we,
  input  wire logic [ibs_pkg::AddrW-1:0] res_addr,
  input  wire logic [7:0]               res_wdata,
  output logic [7:0]                    res_rdata
);
  logic [7:0] src_mem [ibs_pkg::Cells];
  logic [7:0] res_mem [ibs_pkg::Cells];

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_waddr] <= src_wdata;
    src_rdata <= src_mem[src_raddr];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_addr] <= res_wdata;
    res_rdata <= res_mem[res_addr];
  end
endmodule
`default_nettype wire

// ===== test/ibs_checker.sv =====
// ----------------------------------------------------------------------------
// ibs_checker: grid smoothing predictor and result scoreboard
// Watches the command, result and register channels, keeps its own copy of
// the grids and registers, runs the smoothing passes on the last load and
// compares every result transfer with the oldest predicted cell.
// ----------------------------------------------------------------------------
module ibs_checker (
  input  logic clk,
  input  logic rst,
  ibs_in_if    in_ch,
  ibs_out_if   out_ch,
  ibs_cfg_if   cfg_ch,
  output int   errors,
  output int   pending
);
  typedef struct {
    logic [7:0]                smoothed;
    logic                      last_cell;
    logic [ibs_pkg::PassW-1:0] pass_count;
    logic                      limit_hit;
  } cell_out_t;

  cell_out_t                 expected_cells[$];
  logic [7:0]                rows_reg, cols_reg, thresh_reg;
  logic [ibs_pkg::PassW-1:0] passes_reg;
  logic [7:0]                loaded[ibs_pkg::Cells];
  logic [7:0]                smoothed_grid[ibs_pkg::Cells];
  int                        load_pos, read_pos, passes_done;
  bit                        grid_ready, stopped_by_limit;

  function automatic int clamp_dim(logic [7:0] v, int top);
    if (v == 0) return 1;
    return (v > top) ? top : int'(v);
  endfunction

  function automatic int grid_val(bit from_loaded, int r, int c, int nr, int nc);
    if (r < 0 || c < 0 || r >= nr || c >= nc) return 0;
    return from_loaded ? loaded[r*ibs_pkg::MaxCols+c]
                       : smoothed_grid[r*ibs_pkg::MaxCols+c];
  endfunction

  // Later passes read cells already updated in this pass (in place).
  function automatic void smooth_once(bit from_loaded, int nr, int nc);
    int sum, div;
    bit edge_r, edge_c;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        sum = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            sum += grid_val(from_loaded, r+dr, c+dc, nr, nc);
        edge_r = (r == 0 || r == nr-1);
        edge_c = (c == 0 || c == nc-1);
        div = (!edge_r && !edge_c) ? 9 : (edge_r && edge_c) ? 4 : 6;
        smoothed_grid[r*ibs_pkg::MaxCols+c] = 8'(sum / div);
      end
    end
  endfunction

  // Zero neighbours are skipped; no nonzero neighbour at all counts as settled.
  function automatic bit grid_settled(int nr, int nc);
    bit any;
    int worst, v, w, d;
    any = 0;
    worst = 0;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) begin
        v = grid_val(0, r, c, nr, nc);
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0) continue;
            w = grid_val(0, r+dr, c+dc, nr, nc);
            if (w == 0) continue;
            d = (v > w) ? v - w : w - v;
            if (!any || d > worst) worst = d;
            any = 1;
          end
      end
    return !any || worst <= thresh_reg;
  endfunction

  function automatic void smooth_grid(int nr, int nc);
    int limit;
    limit = (passes_reg == 0) ? 1 : int'(passes_reg);
    passes_done = 0;
    stopped_by_limit = 0;
    forever begin
      smooth_once(passes_done == 0, nr, nc);
      passes_done++;
      if (grid_settled(nr, nc)) break;
      if (passes_done >= limit) begin
        stopped_by_limit = 1;
        break;
      end
    end
    grid_ready = 1;
    read_pos = 0;
  endfunction

  function automatic void take_command(logic cmd, logic [7:0] pixel);
    int nr, nc, total;
    cell_out_t e;
    nr = clamp_dim(rows_reg, ibs_pkg::MaxRows);
    nc = clamp_dim(cols_reg, ibs_pkg::MaxCols);
    total = nr * nc;
    if (cmd == ibs_pkg::CmdLoad) begin
      if (grid_ready) begin
        grid_ready = 0;
        load_pos = 0;
      end
      if (load_pos >= total) load_pos = 0;
      loaded[(load_pos / nc)*ibs_pkg::MaxCols + load_pos % nc] = pixel;
      load_pos++;
      if (load_pos >= total) begin
        load_pos = 0;
        smooth_grid(nr, nc);
      end
    end else if (grid_ready) begin
      if (read_pos >= total) read_pos = 0;
      e.smoothed   = smoothed_grid[(read_pos / nc)*ibs_pkg::MaxCols + read_pos % nc];
      e.last_cell  = (read_pos == total-1);
      e.pass_count = ibs_pkg::PassW'(passes_done);
      e.limit_hit  = stopped_by_limit;
      expected_cells.push_back(e);
      read_pos = e.last_cell ? 0 : read_pos + 1;
    end
  endfunction

  always @(posedge clk) begin
    cell_out_t e;
    if (rst) begin
      rows_reg   = 8;
      cols_reg   = 8;
      thresh_reg = 1;
      passes_reg = 1000;
      load_pos = 0;
      read_pos = 0;
      passes_done = 0;
      grid_ready = 0;
      stopped_by_limit = 0;
      expected_cells.delete();
      errors <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          ibs_pkg::RegRows:   rows_reg   = cfg_ch.data[7:0];
          ibs_pkg::RegCols:   cols_reg   = cfg_ch.data[7:0];
          ibs_pkg::RegThresh: thresh_reg = cfg_ch.data[7:0];
          ibs_pkg::RegPasses: passes_reg = cfg_ch.data;
          default: ;
        endcase
        if (cfg_ch.index == ibs_pkg::RegRows || cfg_ch.index == ibs_pkg::RegCols) begin
          load_pos = 0;
          read_pos = 0;
          grid_ready = 0;
        end
      end
      if (in_ch.valid && in_ch.ready) take_command(in_ch.cmd, in_ch.pixel);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: unexpected result smoothed=%0d last=%0d passes=%0d limit=%0d",
                   $time, out_ch.smoothed, out_ch.last_cell, out_ch.pass_count,
                   out_ch.limit_hit);
          errors <= errors + 1;
        end else begin
          e = expected_cells.pop_front();
          if (out_ch.smoothed !== e.smoothed || out_ch.last_cell !== e.last_cell ||
              out_ch.pass_count !== e.pass_count || out_ch.limit_hit !== e.limit_hit) begin
            $display("%0t: mismatch expected smoothed=%0d last=%0d passes=%0d limit=%0d",
                     $time, e.smoothed, e.last_cell, e.pass_count, e.limit_hit);
            $display("%0t:          actual smoothed=%0d last=%0d passes=%0d limit=%0d",
                     $time, out_ch.smoothed, out_ch.last_cell, out_ch.pass_count,
                     out_ch.limit_hit);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= expected_cells.size();
  end
endmodule

// ===== test/tb_iterative_box_smoothing.sv =====
// ----------------------------------------------------------------------------
// tb_iterative_box_smoothing: stimulus and verdict for box smoothing
// Loads grids under changing sizes, thresholds and pass limits, reads the
// results back with random gaps and stalls; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb_iterative_box_smoothing;
  logic clk = 0;
  logic rst;
  int   errors, pending;
  int   sent = 0;
  int   hold = 0;
  bit   quiet = 0;

  ibs_in_if  in_ch ();
  ibs_out_if out_ch ();
  ibs_cfg_if cfg_ch ();

  iterative_box_smoothing u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ibs_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 40_000_000);
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (hold > 0) begin
      out_ch.ready <= 1'b0;
      hold <= hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      hold <= pick_gap();
    end
  end

  task automatic send(logic cmd, logic [7:0] pixel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.pixel <= pixel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Hold the command channel low and drain every outstanding result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // fill < 0 gives random pixels.
  task automatic load_cells(int n, int fill);
    for (int i = 0; i < n; i++)
      send(ibs_pkg::CmdLoad, (fill < 0) ? rand_pixel() : 8'(fill));
  endtask

  task automatic read_cells(int n);
    for (int i = 0; i < n; i++) send(ibs_pkg::CmdRead, 8'($urandom));
  endtask

  task automatic configure(int r, int c, int th, int mp);
    write_reg(ibs_pkg::RegRows, 16'(r));
    write_reg(ibs_pkg::RegCols, 16'(c));
    write_reg(ibs_pkg::RegThresh, 16'(th));
    write_reg(ibs_pkg::RegPasses, 16'(mp));
  endtask

  function automatic int dim_of(int v);
    if (v == 0) return 1;
    return (v > 128) ? 128 : v;
  endfunction

  initial begin
    int r, c, total, th, mp;
    rst <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= ibs_pkg::CmdLoad;
    in_ch.pixel  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= ibs_pkg::RegRows;
    cfg_ch.data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a flat 8x8 grid settles after one pass; reads wrap.
    load_cells(64, 255);
    read_cells(67);
    settle();

    // Single cell, pass limit of zero, read before any grid is done.
    configure(1, 1, 0, 0);
    read_cells(2);
    load_cells(1, -1);
    read_cells(2);
    settle();

    // Zero rows acts as one, oversize cols saturate; wide threshold.
    configure(0, 255, 255, 65535);
    load_cells(128, -1);
    read_cells(129);
    settle();

    // One tall column, tight threshold, short pass limit.
    configure(255, 0, 0, 3);
    load_cells(128, -1);
    read_cells(128);
    settle();

    // 3x3 with a single pass, then a reload after done.
    configure(3, 3, 0, 1);
    load_cells(9, -1);
    read_cells(4);
    load_cells(9, -1);
    read_cells(9);
    settle();

    while (sent < 1250) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(7, 16);
        c = $urandom_range(1, 4);
      end else begin
        r = $urandom_range(0, 6);
        c = $urandom_range(0, 6);
      end
      if ($urandom_range(0, 1)) begin
        int t;
        t = r;
        r = c;
        c = t;
      end
      total = dim_of(r) * dim_of(c);
      case ($urandom_range(0, 5))
        0: th = 0;
        1: th = 255;
        default: th = $urandom_range(0, 4);
      endcase
      case ($urandom_range(0, 19))
        0: mp = 0;
        1: mp = (total <= 9) ? 65535 : 12;
        default: mp = $urandom_range(1, 6);
      endcase
      configure(r, c, th, mp);
      if ($urandom_range(0, 3) == 0) read_cells($urandom_range(1, 2));
      if (total > 1 && $urandom_range(0, 4) == 0) begin
        load_cells($urandom_range(1, total - 1), -1);
        read_cells(1);
        settle();
        write_reg(ibs_pkg::RegRows, 16'(r));
      end
      load_cells(total, -1);
      read_cells($urandom_range(1, total + 3));
      if ($urandom_range(0, 3) == 0) begin
        load_cells(total, -1);
        read_cells($urandom_range(1, total));
      end
      settle();
    end
    quiet = 0;

    settle();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/ibs_pkg.sv
rtl/ibs_if.sv
rtl/ibs_engine.sv
rtl/ibs_grids.sv
rtl/iterative_box_smoothing.sv
test/ibs_checker.sv
test/tb_iterative_box_smoothing.sv
